>>> rtl/core/encoder_speed_accel_meter_assert.svh
// Assertion macros for the encoder meter
`ifndef ENCODER_SPEED_ACCEL_METER_ASSERT_SVH
`define ENCODER_SPEED_ACCEL_METER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define ESAM_AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("esam check failed");

// Next-cycle implication, checked outside reset
`define ESAM_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("esam check failed");

`endif

>>> rtl/core/esam_pkg.sv
`timescale 1ns / 1ps
package esam_pkg;

  localparam int DIV_W = 41;
  localparam int DSR_W = 32;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_EDGE  = 2'd1,
    MODE_CLR1  = 2'd2,
    MODE_CLR2  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_DIVIDER = 2'd0,
    REG_MAXSTEP = 2'd1,
    REG_TIMEOUT = 2'd2,
    REG_INVERT  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic                    start;
    logic signed [DIV_W-1:0] dividend;
    logic [DSR_W-1:0]        divisor;
  } div_req_t;

endpackage

>>> rtl/core/esam_div.sv
`timescale 1ns / 1ps
module esam_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  esam_pkg::div_req_t              req,
  output logic                            done,
  output logic signed [esam_pkg::DIV_W-1:0] quotient
);
  import esam_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               neg_r, neg_nxt;
  logic [DIV_W-1:0]   mag_r, mag_nxt;
  logic [DSR_W-1:0]   rem_r, rem_nxt;
  logic [DSR_W-1:0]   dsr_r, dsr_nxt;
  logic [DSR_W:0]     rem_sh;
  logic               ge;

  assign rem_sh = {rem_r, mag_r[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_W);
      neg_nxt  = req.dividend[DIV_W-1];
      mag_nxt  = req.dividend[DIV_W-1] ? DIV_W'(-req.dividend) : DIV_W'(req.dividend);
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? DSR_W'(rem_sh - {1'b0, dsr_r}) : DSR_W'(rem_sh);
      mag_nxt = {mag_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(mag_r) : $signed(mag_r);

endmodule

>>> rtl/core/encoder_speed_accel_meter.sv
`timescale 1ns / 1ps
// Encoder speed and acceleration meter. Each request (1 ms tick, pulse edge or
// clear of a position total) returns exactly one result with speed x10,
// acceleration and both positions over the count divider. All quotients go
// through one shared restoring divider that retires one quotient bit per
// cycle. A request without a speed sample presents its result after two
// position quotients, a tick that forces a sample after scale, speed and
// position quotients, and an edge sample after scale, speed, acceleration and
// position quotients. A new request is taken once the previous one has moved
// into the output register; a stalled output holds a finished result until it
// is taken.
module encoder_speed_accel_meter #(
  parameter int COUNTER_MODULUS = 65536,
  parameter int HOLDOFF_TICKS   = 61
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [15:0]        in_counter_sample,
  input  logic [31:0]        in_now_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_speed_x10,
  output logic signed [31:0] out_acceleration,
  output logic signed [31:0] out_position_one,
  output logic signed [31:0] out_position_two,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import esam_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_SCALE, S_VGO, S_V, S_AGO, S_ACC, S_PSTART, S_POS1, S_DONE
  } state_t;

  localparam logic signed [17:0] MOD18 = 18'(COUNTER_MODULUS);
  localparam logic [5:0]         HOLD6 = 6'(HOLDOFF_TICKS);

  state_t state_r;
  logic   pos2_r;

  logic [13:0] divider_r;
  logic [14:0] max_step_r;
  logic [15:0] timeout_r;
  logic        invert_r;

  logic [1:0]  mode_r;
  logic [15:0] cnt_r;
  logic [31:0] now_r;

  logic [5:0]         phase_r;
  logic [15:0]        last_counter_r;
  logic [31:0]        last_time_r;
  logic [31:0]        total_one_r, total_two_r;
  logic signed [31:0] speed_now_r, speed_prev_r, accel_now_r;
  logic signed [17:0] d_r;
  logic [31:0]        ival_r;
  logic [13:0]        scale_r;
  logic signed [31:0] v_r, f_r;
  logic signed [31:0] pos1_r, pos2v_r;
  logic               out_valid_r;
  logic signed [31:0] o_speed_r, o_accel_r, o_pos1_r, o_pos2_r;

  logic                    div_start_r;
  logic signed [DIV_W-1:0] div_num_r;
  logic [DSR_W-1:0]        div_den_r;
  div_req_t                div_req;
  logic                    div_done;
  logic signed [DIV_W-1:0] div_q;

  function automatic logic signed [17:0] cdiff(input logic [15:0] from_v,
                                               input logic [15:0] to_v,
                                               input logic [14:0] ms,
                                               input logic        inv);
    logic signed [17:0] d0, d1, d2, msd;
    begin
      msd = $signed({3'b0, ms});
      d0  = $signed({2'b0, to_v}) - $signed({2'b0, from_v});
      d1  = (d0 > msd) ? d0 - MOD18 : d0;
      d2  = (d1 < -msd) ? d1 + MOD18 : d1;
      cdiff = inv ? -d2 : d2;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [DIV_W-1:0] x);
    begin
      if (x > $signed(DIV_W'(32'h7FFFFFFF)))
        sat32 = 32'sh7FFFFFFF;
      else if (x < -$signed(DIV_W'(33'h080000000)))
        sat32 = 32'sh80000000;
      else
        sat32 = x[31:0];
    end
  endfunction

  logic signed [17:0] d_now, pend;
  logic [31:0]        dt;
  logic [15:0]        tmo;
  logic [13:0]        eff_div;
  logic [5:0]         phase_tk;
  logic signed [31:0] prod;
  logic signed [32:0] fsum, fdiff;
  logic signed [31:0] fval;
  logic signed [DIV_W-1:0] acc_num;
  logic               smp;
  logic               div_go;

  assign d_now   = cdiff(last_counter_r, cnt_r, max_step_r, invert_r);
  assign pend    = d_now;
  assign dt      = now_r - last_time_r;
  assign tmo     = (timeout_r == 16'd0) ? 16'd1 : timeout_r;
  assign eff_div = (divider_r == 14'd0) ? 14'd1 : divider_r;
  assign phase_tk = (phase_r == 6'd2) ? 6'd1 :
                    (phase_r > 6'd2) ? phase_r - 6'd1 : phase_r;
  assign prod    = 32'(d_r * $signed({1'b0, scale_r}));
  assign fsum    = 33'($signed(div_q[31:0])) + 33'(speed_prev_r);
  assign fval    = fsum[32:1];
  assign fdiff   = 33'(f_r) - 33'(speed_prev_r);
  assign acc_num = (DIV_W'(fdiff) <<< 6) + (DIV_W'(fdiff) <<< 5) + (DIV_W'(fdiff) <<< 2);

  assign smp    = ((mode_t'(mode_r) == MODE_TICK) && (dt >= {16'd0, tmo})) ||
                  ((mode_t'(mode_r) == MODE_EDGE) && (phase_r == 6'd1));
  assign div_go = ((state_r == S_PREP) && smp) || (state_r == S_VGO) ||
                  (state_r == S_AGO) || (state_r == S_PSTART) ||
                  ((state_r == S_POS1) && div_done && !pos2_r);

  assign div_req = '{start: div_start_r, dividend: div_num_r, divisor: div_den_r};

  esam_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      pos2_r         <= 1'b0;
      divider_r      <= 14'd4;
      max_step_r     <= 15'd30000;
      timeout_r      <= 16'd100;
      invert_r       <= 1'b0;
      phase_r        <= '0;
      last_counter_r <= '0;
      last_time_r    <= '0;
      total_one_r    <= '0;
      total_two_r    <= '0;
      speed_now_r    <= '0;
      speed_prev_r   <= '0;
      accel_now_r    <= '0;
      out_valid_r    <= 1'b0;
      div_start_r    <= 1'b0;
    end else begin
      div_start_r <= div_go;
      if (out_valid_r && !out_stall && state_r != S_DONE) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_DIVIDER: divider_r  <= cfg_data[13:0];
          REG_MAXSTEP: max_step_r <= cfg_data[14:0];
          REG_TIMEOUT: timeout_r  <= cfg_data;
          REG_INVERT:  invert_r   <= cfg_data[0];
          default:     ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r  <= in_mode;
            cnt_r   <= in_counter_sample;
            now_r   <= in_now_ms;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          d_r   <= d_now;
          state_r <= S_PSTART;
          unique case (mode_t'(mode_r))
            MODE_TICK: begin
              phase_r <= phase_tk;
              if (dt >= {16'd0, tmo}) begin
                ival_r         <= {16'd0, tmo};
                total_one_r    <= total_one_r + 32'(d_now);
                total_two_r    <= total_two_r + 32'(d_now);
                last_counter_r <= cnt_r;
                last_time_r    <= now_r;
                phase_r        <= HOLD6;
                div_num_r      <= DIV_W'(10000);
                div_den_r      <= DSR_W'(eff_div);
                state_r        <= S_SCALE;
              end
            end
            MODE_EDGE: begin
              if (phase_r == 6'd0) begin
                last_counter_r <= cnt_r;
                last_time_r    <= now_r;
                phase_r        <= HOLD6;
              end else if (phase_r == 6'd1) begin
                ival_r         <= (dt == 32'd0) ? 32'd1 : dt;
                total_one_r    <= total_one_r + 32'(d_now);
                total_two_r    <= total_two_r + 32'(d_now);
                last_counter_r <= cnt_r;
                last_time_r    <= now_r;
                phase_r        <= HOLD6;
                div_num_r      <= DIV_W'(10000);
                div_den_r      <= DSR_W'(eff_div);
                state_r        <= S_SCALE;
              end
            end
            MODE_CLR1: total_one_r <= '0;
            MODE_CLR2: total_two_r <= '0;
            default:   ;
          endcase
        end
        S_SCALE: begin
          if (div_done) begin
            scale_r <= div_q[13:0];
            state_r <= S_VGO;
          end
        end
        S_VGO: begin
          div_num_r <= DIV_W'(prod);
          div_den_r <= ival_r;
          state_r   <= S_V;
        end
        S_V: begin
          if (div_done) begin
            v_r <= div_q[31:0];
            f_r <= fval;
            if (mode_t'(mode_r) == MODE_TICK) begin
              speed_now_r  <= fval;
              speed_prev_r <= fval;
              accel_now_r  <= '0;
              state_r      <= S_PSTART;
            end else begin
              state_r <= S_AGO;
            end
          end
        end
        S_AGO: begin
          div_num_r <= acc_num;
          div_den_r <= ival_r;
          state_r   <= S_ACC;
        end
        S_ACC: begin
          if (div_done) begin
            accel_now_r  <= sat32(div_q);
            speed_prev_r <= f_r;
            speed_now_r  <= v_r;
            state_r      <= S_PSTART;
          end
        end
        S_PSTART: begin
          div_num_r <= DIV_W'($signed(total_one_r)) + DIV_W'(pend);
          div_den_r <= DSR_W'(eff_div);
          pos2_r    <= 1'b0;
          state_r   <= S_POS1;
        end
        S_POS1: begin
          if (div_done) begin
            if (!pos2_r) begin
              pos1_r    <= sat32(div_q);
              pos2_r    <= 1'b1;
              div_num_r <= DIV_W'($signed(total_two_r)) + DIV_W'(pend);
              div_den_r <= DSR_W'(eff_div);
            end else begin
              pos2v_r <= sat32(div_q);
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            o_speed_r   <= speed_now_r;
            o_accel_r   <= accel_now_r;
            o_pos1_r    <= pos1_r;
            o_pos2_r    <= pos2v_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_speed_x10    = o_speed_r;
  assign out_acceleration = o_accel_r;
  assign out_position_one = o_pos1_r;
  assign out_position_two = o_pos2_r;

`include "encoder_speed_accel_meter_assert.svh"

  `ESAM_AST_NXT(a_take_blocks, in_valid && !in_stall, in_stall)
  `ESAM_AST_NOW(a_phase_range, 1'b1, phase_r <= HOLD6)
  `ESAM_AST_NOW(a_done_busy, div_done, state_r != S_IDLE && state_r != S_DONE)

endmodule
